/* rtl/integer_matrix_power_defines.svh */
// ----------------------------------------------------------------------------
// integer_matrix_power_defines
// Assertion macros shared by the matrix power RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_POWER_DEFINES_SVH
`define INTEGER_MATRIX_POWER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define IMP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during rst
`define IMP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/imp_pkg.sv */
// ----------------------------------------------------------------------------
// imp_pkg
// Types and constants shared by the matrix power controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package imp_pkg;

  localparam int DATA_W = 32;
  localparam int EXP_W  = 31;

  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_START = 1'b1;
  localparam logic [2:0] DIM_RESET = 3'd4;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_INIT   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_MAC    = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_COPY   = 8'b0010_0000,
    ST_OUT_RD = 8'b0100_0000,
    ST_OUT_WR = 8'b1000_0000
  } imp_state_t;

  typedef struct packed {
    logic load_en;
    logic init_en;
    logic mac_en;
    logic mac_first;
    logic mac_last;
    logic sq_mode;
    logic copy_en;
    logic out_rd;
    logic out_load;
    logic out_last;
  } imp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_stall;
  } imp_stat_t;

endpackage

`default_nettype wire

/* rtl/imp_in_if.sv */
// ----------------------------------------------------------------------------
// imp_in_if
// Input channel: load and start words.
// ----------------------------------------------------------------------------
`default_nettype none

interface imp_in_if import imp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [1:0]               row;
  logic [1:0]               col;
  logic signed [DATA_W-1:0] value;
  logic [EXP_W-1:0]         exponent;

  modport source (output valid, cmd, row, col, value, exponent, input ready);
  modport sink   (input valid, cmd, row, col, value, exponent, output ready);
endinterface

`default_nettype wire

/* rtl/imp_out_if.sv */
// ----------------------------------------------------------------------------
// imp_out_if
// Output channel: result elements, row by row.
// ----------------------------------------------------------------------------
`default_nettype none

interface imp_out_if import imp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               out_row;
  logic [1:0]               out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

/* rtl/imp_dp.sv */
// ----------------------------------------------------------------------------
// imp_dp
// Matrix stores, shared multiply-accumulate pipeline and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_matrix_power_defines.svh"

module imp_dp import imp_pkg::*; #(
  parameter int MAX_DIM = 4,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CELLS  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  imp_cmd_t                 cmd,
  output imp_stat_t                stat,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [IDX_W-1:0]         idx_j,
  input  logic [IDX_W-1:0]         idx_k,
  input  logic [1:0]               ld_row,
  input  logic [1:0]               ld_col,
  input  logic signed [DATA_W-1:0] ld_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [1:0]               out_row,
  output logic [1:0]               out_col,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  function automatic logic [ADDR_W-1:0] cell_addr(input int r, input int c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

  logic [DATA_W-1:0] sq_mem  [CELLS];
  logic [DATA_W-1:0] run_mem [CELLS];
  logic [DATA_W-1:0] acc_mem [CELLS];
  logic [DATA_W-1:0] scr_mem [CELLS];

  logic [DATA_W-1:0] sq_rd, acc_rd, run_a_rd, run_b_rd, scr_rd;

  logic [ADDR_W-1:0] addr_ij, addr_ik, addr_kj, ld_addr, acc_raddr;
  logic              ld_ok;

  logic              init_d;
  logic [ADDR_W-1:0] init_addr;
  logic              cp_valid, cp_sq;
  logic [ADDR_W-1:0] cp_addr;

  logic              s1_valid, s1_first, s1_last, s1_sq;
  logic [ADDR_W-1:0] s1_addr;
  logic              s2_valid, s2_first, s2_last;
  logic [ADDR_W-1:0] s2_addr;
  logic [DATA_W-1:0] prod, sum, sum_next, lhs;
  logic [2*DATA_W-1:0] prod_full;

  assign addr_ij   = cell_addr(int'(idx_i), int'(idx_j));
  assign addr_ik   = cell_addr(int'(idx_i), int'(idx_k));
  assign addr_kj   = cell_addr(int'(idx_k), int'(idx_j));
  assign ld_addr   = cell_addr(int'(ld_row), int'(ld_col));
  assign ld_ok     = (int'(ld_row) < MAX_DIM) && (int'(ld_col) < MAX_DIM);
  assign acc_raddr = cmd.out_rd ? addr_ij : addr_ik;

  // loaded matrix
  always_ff @(posedge clk) begin
    if (cmd.load_en && ld_ok) begin
      sq_mem[ld_addr] <= ld_value;
    end
    if (cmd.init_en) begin
      sq_rd <= sq_mem[addr_ij];
    end
  end

  // accumulator: identity at start, products copied back from scratch
  always_ff @(posedge clk) begin
    if (cmd.init_en) begin
      acc_mem[addr_ij] <= (idx_i == idx_j) ? DATA_W'(1) : '0;
    end else if (cp_valid && !cp_sq) begin
      acc_mem[cp_addr] <= scr_rd;
    end
    if (cmd.mac_en || cmd.out_rd) begin
      acc_rd <= acc_mem[acc_raddr];
    end
  end

  // running square, two read ports for squaring
  always_ff @(posedge clk) begin
    if (init_d) begin
      run_mem[init_addr] <= sq_rd;
    end else if (cp_valid && cp_sq) begin
      run_mem[cp_addr] <= scr_rd;
    end
    if (cmd.mac_en) begin
      run_a_rd <= run_mem[addr_ik];
      run_b_rd <= run_mem[addr_kj];
    end
  end

  // product scratch
  always_ff @(posedge clk) begin
    if (s2_valid && s2_last) begin
      scr_mem[s2_addr] <= sum_next;
    end
    if (cmd.copy_en) begin
      scr_rd <= scr_mem[addr_ij];
    end
  end

  assign lhs       = s1_sq ? run_a_rd : acc_rd;
  assign prod_full = lhs * run_b_rd;
  assign sum_next  = s2_first ? prod : sum + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_d   <= 1'b0;
      cp_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      init_d   <= cmd.init_en;
      cp_valid <= cmd.copy_en;
      s1_valid <= cmd.mac_en;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    init_addr <= addr_ij;
    cp_addr   <= addr_ij;
    cp_sq     <= cmd.sq_mode;
    s1_first  <= cmd.mac_first;
    s1_last   <= cmd.mac_last;
    s1_sq     <= cmd.sq_mode;
    s1_addr   <= addr_ij;
    s2_first  <= s1_first;
    s2_last   <= s1_last;
    s2_addr   <= s1_addr;
    prod      <= prod_full[DATA_W-1:0];
    if (s2_valid) begin
      sum <= sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row   <= 2'(idx_i);
      out_col   <= 2'(idx_j);
      out_value <= acc_rd;
      out_last  <= cmd.out_last;
    end
  end

  assign stat.pipe_busy = s1_valid | s2_valid | cp_valid | init_d;
  assign stat.out_stall = out_valid & ~out_ready;

  `IMP_ASSERT_NOW(a_copy_drained, cmd.copy_en, !s1_valid && !s2_valid)
  `IMP_ASSERT_NOW(a_out_room, cmd.out_load, !(out_valid && !out_ready))
  `IMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

/* rtl/imp_ctrl.sv */
// ----------------------------------------------------------------------------
// imp_ctrl
// Sequencer for square-and-multiply: init, multiply passes, copy, readout.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_matrix_power_defines.svh"

module imp_ctrl import imp_pkg::*; #(
  parameter int MAX_DIM = 4,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [EXP_W-1:0] in_exponent,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_wdata,
  output imp_cmd_t         cmd,
  input  imp_stat_t        stat,
  output logic [IDX_W-1:0] idx_i,
  output logic [IDX_W-1:0] idx_j,
  output logic [IDX_W-1:0] idx_k
);

  imp_state_t       state;
  logic [2:0]       dimension;
  logic [EXP_W-1:0] exp_left;
  logic [IDX_W-1:0] nlast, nlast_next;
  logic             phase_sq, mode;
  logic             ij_last;

  always_comb begin
    if (dimension == 3'd0) begin
      nlast_next = '0;
    end else if (int'(dimension) > MAX_DIM) begin
      nlast_next = IDX_W'(MAX_DIM - 1);
    end else begin
      nlast_next = IDX_W'(dimension - 3'd1);
    end
  end

  assign ij_last  = (idx_i == nlast) && (idx_j == nlast);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_en   = in_valid && in_ready && (in_cmd == CMD_LOAD);
    cmd.init_en   = (state == ST_INIT);
    cmd.mac_en    = (state == ST_MAC);
    cmd.mac_first = (idx_k == '0);
    cmd.mac_last  = (idx_k == nlast);
    cmd.sq_mode   = mode;
    cmd.copy_en   = (state == ST_COPY);
    cmd.out_rd    = (state == ST_OUT_RD);
    cmd.out_load  = (state == ST_OUT_WR) && !stat.out_stall;
    cmd.out_last  = ij_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dimension <= DIM_RESET;
      exp_left  <= '0;
      nlast     <= '0;
      phase_sq  <= 1'b0;
      mode      <= 1'b0;
      idx_i     <= '0;
      idx_j     <= '0;
      idx_k     <= '0;
    end else begin
      if (cfg_we) begin
        dimension <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_cmd == CMD_START) begin
            exp_left <= in_exponent;
            nlast    <= nlast_next;
            phase_sq <= 1'b0;
            idx_i    <= '0;
            idx_j    <= '0;
            state    <= ST_INIT;
          end
        end
        ST_INIT, ST_COPY: begin
          if (idx_j == nlast) begin
            idx_j <= '0;
            idx_i <= idx_i + 1'b1;
          end else begin
            idx_j <= idx_j + 1'b1;
          end
          if (ij_last) begin
            state <= ST_CHECK;
            if (state == ST_COPY) begin
              if (mode) begin
                exp_left <= exp_left >> 1;
                phase_sq <= 1'b0;
              end else begin
                phase_sq <= 1'b1;
              end
            end
          end
        end
        ST_CHECK: begin
          if (!stat.pipe_busy) begin
            idx_i <= '0;
            idx_j <= '0;
            idx_k <= '0;
            if (exp_left == '0) begin
              state <= ST_OUT_RD;
            end else begin
              // multiply into the accumulator first when the bit is set
              mode  <= !(!phase_sq && exp_left[0]);
              state <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (idx_k == nlast) begin
            idx_k <= '0;
            if (idx_j == nlast) begin
              idx_j <= '0;
              idx_i <= idx_i + 1'b1;
            end else begin
              idx_j <= idx_j + 1'b1;
            end
            if (ij_last) begin
              state <= ST_DRAIN;
            end
          end else begin
            idx_k <= idx_k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!stat.pipe_busy) begin
            idx_i <= '0;
            idx_j <= '0;
            state <= ST_COPY;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_WR;
        end
        ST_OUT_WR: begin
          if (!stat.out_stall) begin
            if (ij_last) begin
              state <= ST_IDLE;
            end else begin
              if (idx_j == nlast) begin
                idx_j <= '0;
                idx_i <= idx_i + 1'b1;
              end else begin
                idx_j <= idx_j + 1'b1;
              end
              state <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IMP_ASSERT_NOW(a_mac_exp, state == ST_MAC, exp_left != '0)
  `IMP_ASSERT_NOW(a_mac_idx, state == ST_MAC, idx_i <= nlast && idx_j <= nlast && idx_k <= nlast)
  `IMP_ASSERT_NEXT(a_out_done, cmd.out_load && ij_last, state == ST_IDLE)

endmodule

`default_nettype wire

/* rtl/integer_matrix_power.sv */
// ----------------------------------------------------------------------------
// integer_matrix_power
// Sequence: an init pass, then (bits(e)+ones(e)) multiply passes, each followed
//   by a copy back, then a read state and a write state per result element.
// Only one start runs at a time; the pace is set by the single shared 32x32 multiplier.
// Loads are accepted only while idle. Reset is synchronous: dimension 4,
//   controller idle, output empty; the loaded matrix is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_power import imp_pkg::*; #(
  parameter int MAX_DIM = 4
) (
  input  logic        clk,
  input  logic        rst,
  imp_in_if.sink      in_ch,
  imp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  imp_cmd_t         cmd;
  imp_stat_t        stat;
  logic [IDX_W-1:0] idx_i, idx_j, idx_k;

  imp_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_exponent (in_ch.exponent),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .idx_i       (idx_i),
    .idx_j       (idx_j),
    .idx_k       (idx_k)
  );

  imp_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .idx_i     (idx_i),
    .idx_j     (idx_j),
    .idx_k     (idx_k),
    .ld_row    (in_ch.row),
    .ld_col    (in_ch.col),
    .ld_value  (in_ch.value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_value (out_ch.out_value),
    .out_last  (out_ch.last)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_matrix_power. It loads every element, then
// runs exponentiation starts at each dimension setting and checks each result
// word against a square-and-multiply predictor. Valid and ready are paced at
// random in three mixes, the last of which has no gaps or stalls.
// ----------------------------------------------------------------------------

typedef logic [3:0][3:0][imp_pkg::DATA_W-1:0] matrix_t;

typedef struct packed {
  logic [1:0]                row;
  logic [1:0]                col;
  logic [imp_pkg::DATA_W-1:0] value;
  logic                      last;
} element_t;

class matpow_scoreboard;
  logic [2:0]  dimension;
  matrix_t     loaded;
  element_t    pending_elements[$];
  int unsigned failures;
  int unsigned checked;

  function new();
    dimension = imp_pkg::DIM_RESET;
    loaded    = '0;
    failures  = 0;
    checked   = 0;
  endfunction

  function matrix_t multiply(matrix_t a, matrix_t b, int unsigned n);
    matrix_t                    p;
    logic [imp_pkg::DATA_W-1:0] sum;
    p = '0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        sum = '0;
        for (int k = 0; k < n; k++) sum = sum + a[i][k] * b[k][j];
        p[i][j] = sum;
      end
    end
    return p;
  endfunction

  function void note_word(logic cmd, logic [1:0] row, logic [1:0] col,
                          logic [imp_pkg::DATA_W-1:0] value,
                          logic [imp_pkg::EXP_W-1:0] exponent);
    matrix_t                   acc;
    matrix_t                   sq;
    logic [imp_pkg::EXP_W-1:0] bits_left;
    int unsigned               n;
    element_t                  e;
    if (cmd == imp_pkg::CMD_LOAD) begin
      loaded[row][col] = value;
      return;
    end
    n = (dimension == 0) ? 1 : (dimension > 4) ? 4 : dimension;
    acc = '0;
    for (int i = 0; i < 4; i++) acc[i][i] = 1;
    sq = loaded;
    bits_left = exponent;
    while (bits_left != 0) begin
      if (bits_left[0]) acc = multiply(acc, sq, n);
      sq = multiply(sq, sq, n);
      bits_left = bits_left >> 1;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        e.row   = 2'(i);
        e.col   = 2'(j);
        e.value = acc[i][j];
        e.last  = (i == n - 1) && (j == n - 1);
        pending_elements.push_back(e);
      end
    end
  endfunction

  function void check_result(element_t got);
    element_t want;
    if (pending_elements.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected word: row %0d col %0d value %0d last %0b",
                 got.row, got.col, $signed(got.value), got.last);
      return;
    end
    want = pending_elements.pop_front();
    checked++;
    if (got.row !== want.row || got.col !== want.col ||
        got.value !== want.value || got.last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
                 want.row, want.col, $signed(want.value), want.last,
                 got.row, got.col, $signed(got.value), got.last);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imp_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 30000;
  localparam int WORDS_PER_DIM = 14;

  localparam logic [DATA_W-1:0] CORNER [16] = '{
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0003, 32'hFFFF_FFFE,
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0001_0000, 32'h0000_0002, 32'h8000_0001, 32'h0000_0001
  };
  localparam logic [2:0] DIM_PLAN [9] = '{2, 3, 5, 4, 1, 6, 0, 7, 3};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_wdata = 3'd0;

  int unsigned send_gap_pct   = 34;
  int unsigned recv_stall_pct = 72;
  int unsigned quiet_cycles   = 0;
  int unsigned load_count     = 0;
  int unsigned start_count    = 0;

  matpow_scoreboard board;

  imp_in_if  in_ch ();
  imp_out_if out_ch ();

  integer_matrix_power u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    element_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.row   = out_ch.out_row;
        got.col   = out_ch.out_col;
        got.value = out_ch.out_value;
        got.last  = out_ch.last;
        board.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // no word moved on either channel for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(logic cmd, logic [1:0] row, logic [1:0] col,
                           logic [DATA_W-1:0] value, logic [EXP_W-1:0] exponent);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.row      <= row;
    in_ch.col      <= col;
    in_ch.value    <= value;
    in_ch.exponent <= exponent;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(cmd, row, col, value, exponent);
    if (cmd == CMD_LOAD) load_count++;
    else start_count++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (board.pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(logic [2:0] dim);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= dim;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.dimension = dim;
  endtask

  initial begin
    int unsigned        words;
    logic [DATA_W-1:0] val;
    logic [EXP_W-1:0]  pow;
    board = new();
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_LOAD;
    in_ch.row      = 2'd0;
    in_ch.col      = 2'd0;
    in_ch.value    = '0;
    in_ch.exponent = '0;
    out_ch.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole store first, so that no start ever reads an unloaded element
    for (int i = 0; i < 16; i++)
      send_word(CMD_LOAD, 2'(i / 4), 2'(i % 4), CORNER[i], EXP_W'(i * 37));
    send_word(CMD_START, 2'd3, 2'd3, 32'hFFFF_FFFF, '0);
    send_word(CMD_START, 2'd0, 2'd0, 32'h0, 31'd1);
    send_word(CMD_START, 2'd1, 2'd2, 32'h0, 31'd2);
    send_word(CMD_START, 2'd2, 2'd1, 32'h0, 31'd3);
    send_word(CMD_START, 2'd0, 2'd0, 32'h0, 31'h7FFF_FFFF);
    set_dimension(3'd1);
    send_word(CMD_LOAD, 2'd0, 2'd0, 32'h0000_0003, 31'h7FFF_FFFF);
    send_word(CMD_START, 2'd0, 2'd0, 32'h0, 31'd13);
    set_dimension(3'd0);
    send_word(CMD_START, 2'd0, 2'd0, 32'h0, 31'd2);
    set_dimension(3'd7);
    send_word(CMD_START, 2'd0, 2'd0, 32'h0, 31'd3);

    for (int p = 0; p < 3; p++) begin
      send_gap_pct   = (p == 0) ? 34 : (p == 1) ? 72 : 0;
      recv_stall_pct = (p == 0) ? 72 : (p == 1) ? 34 : 0;
      for (int s = 0; s < 3; s++) begin
        set_dimension(DIM_PLAN[p * 3 + s]);
        words = 0;
        while (words < WORDS_PER_DIM) begin
          repeat ($urandom_range(4, 0)) begin
            case ($urandom_range(3, 0))
              0, 1:    val = $urandom_range(8, 0) - 4;
              2:       val = $urandom;
              default: val = CORNER[$urandom_range(15, 0)];
            endcase
            send_word(CMD_LOAD, 2'($urandom), 2'($urandom), val, EXP_W'($urandom));
            words++;
          end
          case ($urandom_range(9, 0))
            0:       pow = EXP_W'($urandom);
            1, 2:    pow = EXP_W'($urandom_range(1023, 17));
            default: pow = EXP_W'($urandom_range(16, 0));
          endcase
          send_word(CMD_START, 2'($urandom), 2'($urandom), $urandom, pow);
          words++;
        end
      end
    end

    wait_for_results();
    $display("Ran %0d loads and %0d exponentiations, %0d result words checked, %0d failures.",
             load_count, start_count, board.checked, board.failures);
    $display("Dimension settings 0 to 7 were used under three valid/ready pacing mixes.");
    if (board.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
